FILE: sv/binary_to_ascii_number_top_defines.svh
// ----------------------------------------------------------------------------
// binary_to_ascii_number_top_defines.svh
// Assertion macros of the number formatter, used by b2a_emit. They sample on clk
// and are switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_ASCII_NUMBER_TOP_DEFINES_SVH
`define BINARY_TO_ASCII_NUMBER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define B2A_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define B2A_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/b2a_pkg.sv
// ----------------------------------------------------------------------------
// b2a_pkg
// Widths, codes, transfer structs and helper functions of the number
// formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package b2a_pkg;

  // Converted width of the value and derived sizes
  localparam int VALUE_WIDTH = 64;
  localparam int IN_WIDTH    = 64;
  localparam int DEC_DIGITS  = (VALUE_WIDTH * 30103 + 99999) / 100000;
  localparam int DIG_BITS    = DEC_DIGITS * 4;
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);
  localparam int DIG_CNT_W   = $clog2(DEC_DIGITS + 1);

  localparam int LEN_W  = 16;
  localparam int CHAR_W = 7;
  localparam int CMD_W  = 2;

  // Conversion modes
  localparam logic [CMD_W-1:0] CMD_UDEC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HEX    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SDEC32 = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SDEC   = 2'd3;

  localparam logic [LEN_W-1:0] BUF_LEN_RESET = 16'd256;

  // Character codes
  localparam logic [CHAR_W-1:0] CHR_ZERO       = 7'h30;
  localparam logic [CHAR_W-1:0] CHR_MINUS      = 7'h2D;
  localparam logic [CHAR_W-1:0] HEX_LETTER_GAP = 7'd7;  // 'A' - '9' - 1

  typedef logic [VALUE_WIDTH-1:0] mag_t;
  typedef logic [DIG_BITS-1:0]    digits_t;

  // Start of a conversion, from the top level to the converter
  typedef struct packed {
    logic go;
    logic neg;
    logic hex;
    logic clear;
    mag_t mag;
  } conv_req_t;

  // Start of character emission, from the converter to the emitter
  typedef struct packed {
    logic go;
    logic neg;
    logic clear;
  } emit_req_t;

  // Map one digit to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    c = CHR_ZERO + {3'b000, d};
    if (d > 4'd9) begin
      c = c + HEX_LETTER_GAP;
    end
    return c;
  endfunction

  // Add three to every BCD digit of five or more before the next shift
  function automatic digits_t bcd_adjust(input digits_t b);
    digits_t r;
    r = b;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (b[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = b[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/b2a_if.sv
// ----------------------------------------------------------------------------
// b2a_if
// Valid/ready channels of the number formatter: number in, character out.
// ----------------------------------------------------------------------------
`default_nettype none

interface b2a_in_if;
  logic                        valid;
  logic                        ready;
  logic [b2a_pkg::IN_WIDTH-1:0] value;
  logic [b2a_pkg::CMD_W-1:0]   cmd;
  logic                        start_new;

  modport source (output valid, value, cmd, start_new, input ready);
  modport sink   (input valid, value, cmd, start_new, output ready);
endinterface

interface b2a_out_if;
  logic                         valid;
  logic                         ready;
  logic [b2a_pkg::CHAR_W-1:0]   character;
  logic [b2a_pkg::LEN_W-1:0]    position;
  logic                         last;

  modport source (output valid, character, position, last, input ready);
  modport sink   (input valid, character, position, last, output ready);
endinterface

`default_nettype wire

FILE: sv/b2a_dabble.sv
// ----------------------------------------------------------------------------
// b2a_dabble
// Bit-serial converter: shifts the magnitude in one bit per cycle, most
// significant first, into a digit register with BCD correction (decimal) or
// without it (hex).
// ----------------------------------------------------------------------------
`default_nettype none

module b2a_dabble (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire b2a_pkg::conv_req_t req,
  output b2a_pkg::emit_req_t      done,
  output b2a_pkg::digits_t        digits
);

  logic                            busy;
  logic                            done_go;
  logic [b2a_pkg::BIT_CNT_W-1:0]   cnt;
  b2a_pkg::mag_t                   shreg;
  b2a_pkg::digits_t                bcd;
  b2a_pkg::digits_t                adj;
  logic                            neg;
  logic                            hex;
  logic                            clear;

  // Correct digits before the shift in decimal mode only
  assign adj = hex ? bcd : b2a_pkg::bcd_adjust(bcd);

  // Count the bits of one conversion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done_go <= 1'b0;
      cnt     <= '0;
    end else begin
      done_go <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= b2a_pkg::BIT_CNT_W'(b2a_pkg::VALUE_WIDTH);
      end else if (busy) begin
        cnt <= cnt - b2a_pkg::BIT_CNT_W'(1);
        if (cnt == b2a_pkg::BIT_CNT_W'(1)) begin
          busy    <= 1'b0;
          done_go <= 1'b1;
        end
      end
    end
  end

  // Load the magnitude, then shift one bit a cycle into the digit register
  always_ff @(posedge clk) begin
    if (req.go) begin
      shreg <= req.mag;
      bcd   <= '0;
      neg   <= req.neg;
      hex   <= req.hex;
      clear <= req.clear;
    end else if (busy) begin
      bcd   <= {adj[b2a_pkg::DIG_BITS-2:0], shreg[b2a_pkg::VALUE_WIDTH-1]};
      shreg <= shreg << 1;
    end
  end

  assign done   = '{go: done_go, neg: neg, clear: clear};
  assign digits = bcd;

endmodule

`default_nettype wire

FILE: sv/b2a_emit.sv
// ----------------------------------------------------------------------------
// b2a_emit
// Character emitter: walks the digit register one digit a cycle from the top
// while the output is not stalled, drops leading zeros, checks each character
// against the buffer capacity and hands it to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_to_ascii_number_top_defines.svh"

module b2a_emit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire b2a_pkg::emit_req_t          req,
  input  wire b2a_pkg::digits_t            digits,
  input  wire logic [b2a_pkg::LEN_W-1:0]   capacity,
  output logic                             busy,
  b2a_out_if.source                        dout
);

  b2a_pkg::digits_t                dig;
  logic [b2a_pkg::DIG_CNT_W-1:0]   rem;
  logic                            lead;
  logic                            neg_pend;
  logic [b2a_pkg::LEN_W-1:0]       count;
  logic                            out_valid;
  logic [b2a_pkg::CHAR_W-1:0]      out_char;
  logic [b2a_pkg::LEN_W-1:0]       out_pos;
  logic                            out_last;

  logic                            step_en;
  logic [3:0]                      head;
  logic                            final_dig;
  logic [b2a_pkg::CHAR_W-1:0]      cand_char;
  logic                            cand_final;
  logic                            cand_live;
  logic                            fits;
  logic                            more_fits;
  logic                            emit;
  logic                            last_bit;

  // Pick the candidate character and test it against the capacity
  always_comb begin
    step_en   = busy && (!out_valid || dout.ready);
    head      = dig[b2a_pkg::DIG_BITS-1 -: 4];
    final_dig = (rem == b2a_pkg::DIG_CNT_W'(1));
    if (neg_pend) begin
      cand_char  = b2a_pkg::CHR_MINUS;
      cand_final = 1'b0;
      cand_live  = 1'b1;
    end else begin
      cand_char  = b2a_pkg::digit_char(head);
      cand_final = final_dig;
      cand_live  = !(lead && (head == 4'd0) && !final_dig);
    end
    fits      = ({1'b0, count} + 17'd1) < {1'b0, capacity};
    more_fits = ({1'b0, count} + 17'd2) < {1'b0, capacity};
    emit      = step_en && cand_live && fits;
    last_bit  = cand_final || !more_fits;
  end

  // Advance the scan, the written count and the output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rem       <= '0;
      lead      <= 1'b0;
      neg_pend  <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (req.go) begin
        busy     <= 1'b1;
        rem      <= b2a_pkg::DIG_CNT_W'(b2a_pkg::DEC_DIGITS);
        lead     <= 1'b1;
        neg_pend <= req.neg;
        if (req.clear) begin
          count <= '0;
        end
      end else if (step_en) begin
        if (neg_pend) begin
          neg_pend <= 1'b0;
        end else begin
          rem <= rem - b2a_pkg::DIG_CNT_W'(1);
          if (cand_live) begin
            lead <= 1'b0;
          end
          if (final_dig) begin
            busy <= 1'b0;
          end
        end
        if (emit) begin
          count <= count + 16'd1;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Shift the digit register and hold the output payload
  always_ff @(posedge clk) begin
    if (req.go) begin
      dig <= digits;
    end else if (step_en && !neg_pend) begin
      dig <= dig << 4;
    end
    if (emit) begin
      out_char <= cand_char;
      out_pos  <= count;
      out_last <= last_bit;
    end
  end

  assign dout.valid     = out_valid;
  assign dout.character = out_char;
  assign dout.position  = out_pos;
  assign dout.last      = out_last;

  `B2A_ASSERT_NOW(a_start_when_idle, req.go, !busy, "emission started while busy")
  `B2A_ASSERT_NOW(a_scan_complete, $fell(busy), rem == '0, "scan ended with digits left")
  `B2A_ASSERT_NOW(a_valid_from_scan, $rose(out_valid), $past(busy), "character without scan")
  `B2A_ASSERT_NEXT(a_more_follows, emit && !last_bit, busy, "scan stopped before last")

endmodule

`default_nettype wire

FILE: sv/binary_to_ascii_number_top.sv
// ----------------------------------------------------------------------------
// binary_to_ascii_number_top
// Number to ASCII formatter: unsigned decimal, uppercase hex, signed 32-bit
// or signed full-width decimal, written most significant character first
// against a buffer capacity.
// ----------------------------------------------------------------------------
//  channel  role    payload                          transfer when
//  din      sink    value, cmd, start_new            valid & ready
//  dout     source  character, position, last       valid & ready
//  cfg      write   cfg_data -> capacity             cfg_we
//
//  One number passes through loading the bit-serial converter, one shift per
//  bit of VALUE_WIDTH, handing the digits over, a scan of the DEC_DIGITS
//  digit positions (with one more step for a minus sign) and the return to
//  idle; din is ready again once the scan ends, even while the last
//  character still waits.
//  A stall on dout while a character waits holds the scan, cycle for cycle.
//  rst is synchronous: the capacity returns to 256 and the count to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_to_ascii_number_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [b2a_pkg::LEN_W-1:0] cfg_data,
  b2a_in_if.sink                         din,
  b2a_out_if.source                      dout
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                     state;
  logic [1:0]                     state_next;
  logic [b2a_pkg::LEN_W-1:0]      capacity;
  logic                           accept;
  logic                           neg;
  b2a_pkg::mag_t                  vw;
  b2a_pkg::mag_t                  mag;
  logic [31:0]                    v32;
  logic [31:0]                    mag32;
  b2a_pkg::conv_req_t             conv_req;
  b2a_pkg::emit_req_t             emit_req;
  b2a_pkg::digits_t               digits;
  logic                           emit_busy;

  // Hold the buffer capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= b2a_pkg::BUF_LEN_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  assign din.ready = (state == ST_IDLE);
  assign accept    = din.valid && din.ready;

  // Take sign and magnitude of the incoming value
  always_comb begin
    vw    = din.value[b2a_pkg::VALUE_WIDTH-1:0];
    v32   = din.value[31:0];
    mag32 = v32[31] ? (~v32 + 32'd1) : v32;
    unique case (din.cmd)
      b2a_pkg::CMD_SDEC32: begin
        neg = v32[31];
        mag = b2a_pkg::mag_t'(mag32);
      end
      b2a_pkg::CMD_SDEC: begin
        neg = vw[b2a_pkg::VALUE_WIDTH-1];
        mag = neg ? (~vw + b2a_pkg::mag_t'(1)) : vw;
      end
      default: begin
        neg = 1'b0;
        mag = vw;
      end
    endcase
    conv_req = '{go: accept, neg: neg, hex: (din.cmd == b2a_pkg::CMD_HEX),
                 clear: din.start_new, mag: mag};
  end

  // Sequence one number through conversion and emission
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (emit_req.go) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  b2a_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .req    (conv_req),
    .done   (emit_req),
    .digits (digits)
  );

  b2a_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .req      (emit_req),
    .digits   (digits),
    .capacity (capacity),
    .busy     (emit_busy),
    .dout     (dout)
  );

endmodule

`default_nettype wire
